### rtl/rita_pkg.sv
// shared types, constants and digit mapping for the radix integer to ascii converter
package rita_pkg;

	localparam int VALUE_BITS = 32;
	localparam int CHUNK_BITS = 8;
	localparam int CHUNKS     = VALUE_BITS / CHUNK_BITS;
	localparam int CHUNK_W    = $clog2(CHUNKS);
	localparam int CNT_W      = $clog2(VALUE_BITS + 1);
	localparam int RADIX_W    = 6;
	localparam int CHAR_W     = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h41;
	localparam logic [RADIX_W-1:0] DEC_TOP   = 6'd9;
	localparam logic [RADIX_W-1:0] DEC_SPAN  = 6'd10;

	typedef struct packed {
		logic load;
		logic div_step;
		logic calc_pad;
		logic emit;
	} rita_cmd_t;

	typedef struct packed {
		logic in_zero;
		logic digit_end;
		logic quo_zero;
		logic count_full;
		logic empty;
		logic emit_last;
		logic out_free;
	} rita_sts_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d > DEC_TOP) begin
			c = CHAR_A + CHAR_W'(d - DEC_SPAN);
		end else begin
			c = CHAR_ZERO + CHAR_W'(d);
		end
		return c;
	endfunction

endpackage

### rtl/rita_ctrl.sv
// controller state machine for the radix integer to ascii converter
module rita_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rita_pkg::rita_sts_t sts,
	output rita_pkg::rita_cmd_t cmd
);

	typedef enum logic [1:0] {
		IDLE,
		DIV,
		PADC,
		EMIT
	} state_t;

	state_t state_q;
	logic   in_stall_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			IDLE: cmd.load     = in_valid;
			DIV:  cmd.div_step = 1'b1;
			PADC: cmd.calc_pad = 1'b1;
			EMIT: cmd.emit     = !sts.empty && sts.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			in_stall_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						in_stall_q <= 1'b1;
						state_q    <= sts.in_zero ? PADC : DIV;
					end
				end
				DIV: begin
					if (sts.digit_end && (sts.quo_zero || sts.count_full)) begin
						state_q <= PADC;
					end
				end
				PADC: state_q <= EMIT;
				EMIT: begin
					if (sts.empty || (sts.out_free && sts.emit_last)) begin
						state_q    <= IDLE;
						in_stall_q <= 1'b0;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign in_stall = in_stall_q;

endmodule

### rtl/rita_dp.sv
// datapath: chunked digit divider, digit stack, padding count and output register
module rita_dp #(
	parameter int MAX_DIGITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [rita_pkg::VALUE_BITS-1:0]      value,
	input  logic [rita_pkg::RADIX_W-1:0]         radix,
	input  logic [5:0]                           min_digits,
	input  rita_pkg::rita_cmd_t                  cmd,
	output rita_pkg::rita_sts_t                  sts,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [rita_pkg::CHAR_W-1:0]          character,
	output logic                                 last
);

	localparam int MW = $clog2(MAX_DIGITS + 1);
	localparam int SW = (MW > rita_pkg::CNT_W) ? MW : rita_pkg::CNT_W;
	localparam int VB = rita_pkg::VALUE_BITS;
	localparam int CB = rita_pkg::CHUNK_BITS;
	localparam int RW = rita_pkg::RADIX_W;

	logic [VB-1:0]                    val_q;
	logic [RW-1:0]                    radix_q;
	logic [RW-1:0]                    rem_q;
	logic [rita_pkg::CHUNK_W-1:0]     chunk_q;
	logic [rita_pkg::CNT_W-1:0]       count_q;
	logic [MW-1:0]                    min_q;
	logic [MW-1:0]                    pad_q;
	logic [RW-1:0]                    stk_q [VB];
	logic                             out_valid_q;
	logic [rita_pkg::CHAR_W-1:0]      char_q;
	logic                             last_q;

	logic [RW-1:0]                    radix_c;
	logic [SW-1:0]                    min_sat;
	logic [SW-1:0]                    min_ext;
	logic [SW-1:0]                    cnt_ext;
	logic [SW-1:0]                    pad_c;
	logic [RW:0]                      r_c;
	logic [CB-1:0]                    q_c;
	logic [VB-1:0]                    val_next;
	logic                             digit_end;

	// eight restoring steps on the top byte of the running quotient
	always_comb begin
		r_c = {1'b0, rem_q};
		q_c = '0;
		for (int i = 0; i < CB; i++) begin
			r_c = {r_c[RW-1:0], val_q[VB-1-i]};
			if (r_c >= {1'b0, radix_q}) begin
				r_c          = r_c - {1'b0, radix_q};
				q_c[CB-1-i] = 1'b1;
			end
		end
	end

	assign val_next  = {val_q[VB-CB-1:0], q_c};
	assign digit_end = (chunk_q == rita_pkg::CHUNK_W'(rita_pkg::CHUNKS - 1));

	always_comb begin
		if (radix < rita_pkg::RADIX_MIN) begin
			radix_c = rita_pkg::RADIX_MIN;
		end else if (radix > rita_pkg::RADIX_MAX) begin
			radix_c = rita_pkg::RADIX_MAX;
		end else begin
			radix_c = radix;
		end
		min_ext = SW'(min_digits);
		min_sat = (min_ext > SW'(MAX_DIGITS)) ? SW'(MAX_DIGITS) : min_ext;
		cnt_ext = SW'(count_q);
		pad_c   = (SW'(min_q) > cnt_ext) ? (SW'(min_q) - cnt_ext) : '0;
	end

	always_comb begin
		sts            = '0;
		sts.in_zero    = (value == '0);
		sts.digit_end  = digit_end;
		sts.quo_zero   = (val_next == '0);
		sts.count_full = (count_q == rita_pkg::CNT_W'(VB - 1));
		sts.empty      = (pad_q == '0) && (count_q == '0);
		sts.emit_last  = ((pad_q == MW'(1)) && (count_q == '0)) ||
			((pad_q == '0) && (count_q == rita_pkg::CNT_W'(1)));
		sts.out_free   = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q   <= value;
			radix_q <= radix_c;
			min_q   <= min_sat[MW-1:0];
		end else if (cmd.div_step) begin
			val_q <= val_next;
		end
		if (cmd.calc_pad) begin
			pad_q <= pad_c[MW-1:0];
		end else if (cmd.emit && (pad_q != '0)) begin
			pad_q <= pad_q - MW'(1);
		end
		if (cmd.div_step && digit_end) begin
			stk_q[0] <= r_c[RW-1:0];
			for (int i = 1; i < VB; i++) begin
				stk_q[i] <= stk_q[i-1];
			end
		end else if (cmd.emit && (pad_q == '0)) begin
			for (int i = 0; i < VB - 1; i++) begin
				stk_q[i] <= stk_q[i+1];
			end
		end
		if (cmd.emit) begin
			char_q <= (pad_q != '0) ? rita_pkg::CHAR_ZERO : rita_pkg::digit_char(stk_q[0]);
			last_q <= sts.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			chunk_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				rem_q   <= '0;
				chunk_q <= '0;
				count_q <= '0;
			end else if (cmd.div_step) begin
				chunk_q <= chunk_q + rita_pkg::CHUNK_W'(1);
				if (digit_end) begin
					rem_q   <= '0;
					count_q <= count_q + rita_pkg::CNT_W'(1);
				end else begin
					rem_q <= r_c[RW-1:0];
				end
			end else if (cmd.emit && (pad_q == '0)) begin
				count_q <= count_q - rita_pkg::CNT_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rita_pkg::CNT_W'(VB))
		else $error("digit count beyond value width");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !out_stall))
		else $error("character overwrote a waiting beat");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !((pad_q == '0) && (count_q == '0)))
		else $error("emit with nothing left");

	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |=> (rem_q < radix_q))
		else $error("partial remainder not below radix");

endmodule

### rtl/radix_integer_to_ascii.sv
// top level of the radix integer to ascii converter
// Usage: an input beat carries value, radix and min_digits on in_valid/in_stall.
// radix below 2 acts as 2 and above 36 as 36; min_digits saturates at MAX_DIGITS.
// The block answers with a run of ASCII beats on out_valid/out_stall, most
// significant digit first, leading '0' padding up to min_digits, last set on the
// final beat. A zero value gives only the padding, or no beat at all.
// Timing: the divider handles eight quotient bits a cycle, so each digit takes
// one pass over the four bytes of the running quotient; after the digits are
// divided out the padding is computed, then one character goes out per cycle
// while the receiver does not stall. One item is converted at a time; in_stall
// is high from acceptance until the last character sits in the output register,
// so the next item enters while that last beat still waits.
// out_stall holds the output register and pauses character generation.
// Reset (arst_n low) clears the controller and output valid; no beat is pending.
module radix_integer_to_ascii #(
	parameter int MAX_DIGITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] value,
	input  logic [5:0]  radix,
	input  logic [5:0]  min_digits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  character,
	output logic        last
);

	rita_pkg::rita_cmd_t cmd;
	rita_pkg::rita_sts_t sts;

	rita_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	rita_dp #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.radix      (radix),
		.min_digits (min_digits),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.character  (character),
		.last       (last)
	);

endmodule

### dv/tb_top.sv
// self-checking testbench for the radix integer to ascii converter
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DIGITS = 32;
	localparam int RANDOM_NUMBERS = 450;

	typedef struct packed {
		logic [31:0] value;
		logic [5:0]  radix;
		logic [5:0]  min_digits;
		logic        drain;
	} number_job_t;

	typedef struct packed {
		logic [rita_pkg::CHAR_W-1:0] ch;
		logic                        fin;
	} char_beat_t;

	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_SPARSE,
		SINK_DENSE,
		SINK_PERIODIC
	} sink_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] value = '0;
	logic [5:0]  radix = '0;
	logic [5:0]  min_digits = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [6:0]  character;
	logic        last;

	number_job_t job_q[$];
	char_beat_t  char_q[$];
	logic        chars_drained = 1'b1;
	int          err_count = 0;

	int unsigned burst_left;
	int unsigned gap_left;
	sink_mode_t  sink_mode;
	int unsigned sink_left;
	logic [2:0]  sink_phase;

	radix_integer_to_ascii #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.radix     (radix),
		.min_digits(min_digits),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// expected characters of one number, most significant first after the padding
	function automatic void predict_chars(input logic [31:0] v, input logic [5:0] r_in,
			input logic [5:0] m_in);
		int unsigned base;
		int unsigned minimum;
		int unsigned count;
		int unsigned pad;
		int unsigned total;
		int unsigned d;
		logic [31:0] rest;
		logic [5:0]  digs [32];
		logic [rita_pkg::CHAR_W-1:0] ch;
		base = (r_in < rita_pkg::RADIX_MIN) ? rita_pkg::RADIX_MIN :
			((r_in > rita_pkg::RADIX_MAX) ? rita_pkg::RADIX_MAX : r_in);
		minimum = (m_in > MAX_DIGITS) ? MAX_DIGITS : m_in;
		rest = v;
		count = 0;
		while (rest != 0) begin
			digs[count] = 6'(rest % base);
			rest = rest / base;
			count++;
		end
		pad = (minimum > count) ? minimum - count : 0;
		total = pad + count;
		for (int unsigned k = 0; k < total; k++) begin
			d = (k < pad) ? 0 : digs[total - 1 - k];
			ch = (d > 9) ? rita_pkg::CHAR_A + rita_pkg::CHAR_W'(d - 10) :
				rita_pkg::CHAR_ZERO + rita_pkg::CHAR_W'(d);
			char_q.push_back('{ch, k == total - 1});
		end
	endfunction

	task automatic add_number(input logic [31:0] v, input logic [5:0] r, input logic [5:0] m,
			input logic drain);
		job_q.push_back('{v, r, m, drain});
	endtask

	// sender: bursts of beats with random gaps, payload held while stalled
	always @(posedge clk or negedge arst_n) begin
		number_job_t job;
		if (!arst_n) begin
			in_valid <= 1'b0;
			value <= '0;
			radix <= '0;
			min_digits <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!(in_valid && in_stall)) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (job_q.size() != 0 && !(job_q[0].drain && (in_valid || !chars_drained))) begin
				job = job_q.pop_front();
				in_valid <= 1'b1;
				value <= job.value;
				radix <= job.radix;
				min_digits <= job.min_digits;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 16);
					if ($urandom_range(0, 2) == 0)
						gap_left <= 0;
					else if ($urandom_range(0, 7) == 0)
						gap_left <= $urandom_range(20, 200);
					else
						gap_left <= $urandom_range(1, 5);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern, switches between open, sparse, dense and periodic modes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			sink_mode <= SINK_OPEN;
			sink_left <= 0;
			sink_phase <= '0;
		end else begin
			if (sink_left == 0) begin
				sink_mode <= sink_mode_t'($urandom_range(0, 3));
				sink_left <= $urandom_range(50, 400);
			end else begin
				sink_left <= sink_left - 1;
			end
			sink_phase <= sink_phase + 3'd1;
			case (sink_mode)
				SINK_OPEN: out_stall <= 1'b0;
				SINK_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
				SINK_DENSE: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (sink_phase < 3'd5);
			endcase
		end
	end

	// checks output beats against the expected characters, predicts on input beats
	always @(posedge clk) begin : monitor
		char_beat_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (char_q.size() == 0) begin
					$display("%0t ns: unexpected beat, expected none, got character %h last %b",
						$time, character, last);
					err_count++;
				end else begin
					want = char_q.pop_front();
					if (character !== want.ch) begin
						$display("%0t ns: character expected %h got %h", $time, want.ch, character);
						err_count++;
					end
					if (last !== want.fin) begin
						$display("%0t ns: last expected %b got %b", $time, want.fin, last);
						err_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				predict_chars(value, radix, min_digits);
			chars_drained <= (char_q.size() == 0);
		end
	end

	initial begin
		int unsigned sel;
		int unsigned base;
		longint unsigned p;
		logic [31:0] v;
		logic [5:0]  r;
		logic [5:0]  m;

		// directed numbers
		add_number(32'd0, 6'd10, 6'd0, 1'b0);
		add_number(32'd0, 6'd10, 6'd1, 1'b0);
		add_number(32'd0, 6'd16, 6'd32, 1'b0);
		add_number(32'd0, 6'd2, 6'd63, 1'b0);
		add_number(32'hFFFF_FFFF, 6'd2, 6'd0, 1'b0);
		add_number(32'hFFFF_FFFF, 6'd36, 6'd0, 1'b0);
		add_number(32'hFFFF_FFFF, 6'd10, 6'd0, 1'b0);
		add_number(32'hDEAD_BEEF, 6'd16, 6'd0, 1'b0);
		add_number(32'd37, 6'd0, 6'd0, 1'b0);
		add_number(32'd37, 6'd1, 6'd3, 1'b0);
		add_number(32'd1295, 6'd37, 6'd0, 1'b0);
		add_number(32'd1296, 6'd63, 6'd5, 1'b0);
		add_number(32'd35, 6'd36, 6'd0, 1'b0);
		add_number(32'd9, 6'd10, 6'd0, 1'b0);
		add_number(32'd10, 6'd16, 6'd0, 1'b0);
		add_number(32'd7, 6'd8, 6'd33, 1'b0);
		add_number(32'd7, 6'd8, 6'd40, 1'b0);
		add_number(32'd1, 6'd2, 6'd32, 1'b0);
		add_number(32'h8000_0000, 6'd2, 6'd5, 1'b0);
		add_number(32'd12345, 6'd10, 6'd8, 1'b0);
		add_number(32'hAAAA_AAAA, 6'd3, 6'd0, 1'b0);
		add_number(32'd123456789, 6'd36, 6'd2, 1'b0);
		add_number(32'h7FFF_FFFF, 6'd2, 6'd31, 1'b0);

		for (int i = 0; i < RANDOM_NUMBERS; i++) begin
			r = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(2, 36));
			m = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 12));
			sel = $urandom_range(0, 9);
			if (sel < 5) begin
				v = $urandom();
			end else if (sel == 5) begin
				v = $urandom_range(0, 40);
			end else if (sel == 6) begin
				v = '0;
			end else if (sel == 7) begin
				// powers of the base and one below them
				base = (r < 2) ? 2 : ((r > 36) ? 36 : r);
				p = 1;
				repeat ($urandom_range(1, 32)) begin
					if (p * base <= 64'hFFFF_FFFF)
						p = p * base;
				end
				v = 32'(p - $urandom_range(0, 1));
			end else begin
				v = $urandom() >> $urandom_range(0, 31);
			end
			add_number(v, r, m, (i % 97) == 0);
		end

		repeat (2) @(posedge clk);
		#3 arst_n = 1'b1;

		do @(posedge clk); while (job_q.size() != 0 || in_valid);
		do @(posedge clk); while (!chars_drained);
		repeat (400) @(posedge clk);
		if (err_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

### radix_integer_to_ascii.f
rtl/rita_pkg.sv
rtl/rita_ctrl.sv
rtl/rita_dp.sv
rtl/radix_integer_to_ascii.sv
dv/tb_top.sv
